// ===== rtl/cpa_pkg.sv =====
// chirp packet airtime: shared types, register codes and constant tables
// no dependencies; imported by chirp_packet_airtime
`default_nettype none

package cpa_pkg;

  // field and port widths
  localparam int unsigned PlW      = 8;
  localparam int unsigned PsymW    = 10;
  localparam int unsigned AirW     = 36;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 48;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgBwIdx = 2'd0,
    CfgSf    = 2'd1,
    CfgCr    = 2'd2,
    CfgPre   = 2'd3
  } cfg_reg_e;

  // reset values and legal ranges
  localparam logic [3:0]  BwIdxRst = 4'd7;
  localparam logic [3:0]  SfRst    = 4'd12;
  localparam logic [2:0]  CrRst    = 3'd1;
  localparam logic [15:0] PreRst   = 16'd6;
  localparam logic [3:0]  BwIdxMax = 4'd9;
  localparam logic [3:0]  SfMin    = 4'd6;
  localparam logic [3:0]  SfMax    = 4'd12;
  localparam logic [2:0]  CrMin    = 3'd1;
  localparam logic [2:0]  CrMax    = 3'd4;
  localparam logic [15:0] PreMin   = 16'd6;

  // per bandwidth: 250000/bw = num / (den * 2^div2), den odd
  // recip = ceil(2^shr / den), exact for numerators below 2^30
  // de_sf: smallest spreading factor with symbol time above 16 ms
  typedef struct packed {
    logic [11:0] num;
    logic [8:0]  den;
    logic [30:0] recip;
    logic [5:0]  shr;
    logic [1:0]  div2;
    logic [3:0]  de_sf;
  } bw_row_t;

  function automatic bw_row_t bw_row(input logic [3:0] bi);
    bw_row_t r;
    unique case (bi)
      4'd0:    r = '{12'd1250, 9'd39,  31'd1762037866, 6'd36, 2'd0, 4'd7};
      4'd1:    r = '{12'd625,  9'd13,  31'd1321528399, 6'd34, 2'd1, 4'd8};
      4'd2:    r = '{12'd625,  9'd39,  31'd1762037866, 6'd36, 2'd0, 4'd8};
      4'd3:    r = '{12'd625,  9'd13,  31'd1321528399, 6'd34, 2'd2, 4'd9};
      4'd4:    r = '{12'd8,    9'd1,   31'd1073741824, 6'd30, 2'd0, 4'd9};
      4'd5:    r = '{12'd2500, 9'd417, 31'd1318359266, 6'd39, 2'd0, 4'd10};
      4'd6:    r = '{12'd4,    9'd1,   31'd1073741824, 6'd30, 2'd0, 4'd10};
      4'd7:    r = '{12'd2,    9'd1,   31'd1073741824, 6'd30, 2'd0, 4'd11};
      4'd8:    r = '{12'd1,    9'd1,   31'd1073741824, 6'd30, 2'd0, 4'd12};
      default: r = '{12'd1,    9'd1,   31'd1073741824, 6'd30, 2'd1, 4'd13};
    endcase
    return r;
  endfunction

  // ceil(2^16 / k), exact floor(y/k) for y below 2^10 and k up to 12
  function automatic logic [16:0] recip16(input logic [3:0] k);
    logic [16:0] r;
    unique case (k)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      4'd10:   r = 17'd6554;
      4'd11:   r = 17'd5958;
      4'd12:   r = 17'd5462;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/chirp_packet_airtime.sv =====
// chirp packet airtime: top level, eight stage pipeline
// depends on cpa_pkg
`default_nettype none

// Airtime of one chirp-spread-spectrum packet (explicit header, crc on). Each
// payload length transferred on the slave stream gives one result on the master
// stream: the low-data-rate optimize flag, the payload symbol count and the
// total time on air in whole microseconds, truncated. The pipeline takes one
// item per cycle while the master side accepts results, and has eight
// register stages, the last of which presents each result on the master
// side. The depth is set by the chain of reciprocal multiplies that
// stand in for the divisions. Each
// stage holds its item until the next stage is free, so a stalled master side
// backs up stage by stage and the input is refused only when every stage is
// full. Configuration registers (bandwidth index, spreading factor, coding rate
// index, preamble length) are taken on every write transfer and clamped to
// their legal ranges when used; write them only while no item is in flight.
module chirp_packet_airtime (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // config write channel
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic [cpa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [cpa_pkg::CfgDataW-1:0] cfg_data_i,
  // input stream
  input  wire logic                         s_axis_tvalid_i,
  output      logic                         s_axis_tready_o,
  input  wire logic [cpa_pkg::InDataW-1:0]  s_axis_tdata_i,  // [7:0] payload_length
  // result stream
  output      logic                         m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // [0] low_rate_optimize, [10:1] payload_symbols, [46:11] airtime_us, [47] zero
  output      logic [cpa_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import cpa_pkg::*;

  localparam int unsigned NumStg = 8;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [3:0]  bw_idx_q, sf_q;
  logic [2:0]  cr_q;
  logic [15:0] pre_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_idx_q <= BwIdxRst;
      sf_q     <= SfRst;
      cr_q     <= CrRst;
      pre_q    <= PreRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgBwIdx: bw_idx_q <= cfg_data_i[3:0];
        CfgSf:    sf_q     <= cfg_data_i[3:0];
        CfgCr:    cr_q     <= cfg_data_i[2:0];
        CfgPre:   pre_q    <= cfg_data_i;
      endcase
    end
  end

  // clamped settings: user must keep steady while items are in flight; unenforced
  logic [3:0]  bi_c, sf_c, kk_c, s_amt;
  logic [2:0]  cr_c;
  logic [15:0] pre_c;
  logic        de_c;
  bw_row_t     row;

  always_comb begin
    bi_c = (bw_idx_q > BwIdxMax) ? BwIdxMax : bw_idx_q;
    priority if (sf_q < SfMin) sf_c = SfMin;
    else if (sf_q > SfMax)     sf_c = SfMax;
    else                       sf_c = sf_q;
    priority if (cr_q < CrMin) cr_c = CrMin;
    else if (cr_q > CrMax)     cr_c = CrMax;
    else                       cr_c = cr_q;
    pre_c = (pre_q < PreMin) ? PreMin : pre_q;
    row   = bw_row(bi_c);
    // symbol time above 16 ms
    de_c  = (sf_c >= row.de_sf);
    // symbol divisor is 4*(sf - 2*de)
    kk_c  = sf_c - (de_c ? 4'd2 : 4'd0);
    // net left shift of the time term after the odd divisor
    s_amt = sf_c - {2'b00, row.div2};
  end

  // ---------------------------------------------------------------------------
  // stage valid bits and per-stage load enables
  // ---------------------------------------------------------------------------
  logic [NumStg-1:0] v_q, v_d, en;

  always_comb begin
    en[NumStg-1] = !v_q[NumStg-1] || m_axis_tready_i;
    for (int i = NumStg - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
    for (int i = 0; i < NumStg; i++) begin
      if (i == 0) begin
        v_d[i] = en[i] ? s_axis_tvalid_i : v_q[i];
      end else begin
        v_d[i] = en[i] ? v_q[i-1] : v_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready_o = en[0];

  // ---------------------------------------------------------------------------
  // stage 0: symbol numerator, rounded up and pre-divided by four
  // ---------------------------------------------------------------------------
  logic [11:0] num_a, num_b, num, x_sum;
  logic [9:0]  y_q;
  logic [16:0] rcp_q;

  always_comb begin
    num_a = {1'b0, s_axis_tdata_i[PlW-1:0], 3'b000} + 12'd44;
    num_b = {6'b0, sf_c, 2'b00};
    // negative numerator clamps to zero
    num   = (num_a > num_b) ? (num_a - num_b) : 12'd0;
    x_sum = num + {6'b0, kk_c, 2'b00} - 12'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      y_q   <= x_sum[11:2];
      rcp_q <= recip16(kk_c);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: coding blocks = floor(y / kk) by reciprocal
  // ---------------------------------------------------------------------------
  logic [26:0] blk_prod;
  logic [7:0]  blk_q;

  assign blk_prod = {17'b0, y_q} * {10'b0, rcp_q};

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      blk_q <= blk_prod[23:16];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: payload symbols and quarter-symbol count of the whole packet
  // ---------------------------------------------------------------------------
  logic [3:0]  cr4;
  logic [11:0] blk_sym, psym_full;
  logic [18:0] sym_sum, qtr;
  logic [PsymW-1:0] psym2_q;
  logic [18:0] qtr_q;

  always_comb begin
    cr4       = {1'b0, cr_c} + 4'd4;
    blk_sym   = {4'b0, blk_q} * {8'b0, cr4};
    psym_full = blk_sym + 12'd8;
    sym_sum   = {3'b0, pre_c} + {7'b0, psym_full};
    // preamble + 4.25 + payload symbols, in quarters
    qtr       = {sym_sum[16:0], 2'b00} + 19'd17;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      psym2_q <= psym_full[PsymW-1:0];
      qtr_q   <= qtr;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: scale by the bandwidth numerator
  // ---------------------------------------------------------------------------
  logic [30:0] p_prod;
  logic [29:0] p3_q;
  logic [PsymW-1:0] psym3_q;

  assign p_prod = {12'b0, qtr_q} * {19'b0, row.num};

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      p3_q    <= p_prod[29:0];
      psym3_q <= psym2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: quotient by the odd bandwidth divisor
  // ---------------------------------------------------------------------------
  logic [60:0] q_prod;
  logic [29:0] q4_q, p4_q;
  logic [PsymW-1:0] psym4_q;

  assign q_prod = {31'b0, p3_q} * {30'b0, row.recip};

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      q4_q    <= 30'(q_prod >> row.shr);
      p4_q    <= p3_q;
      psym4_q <= psym3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: remainder of that division
  // ---------------------------------------------------------------------------
  logic [38:0] qd_prod;
  logic [29:0] rem_full;
  logic [8:0]  r_q;
  logic [29:0] q5_q;
  logic [PsymW-1:0] psym5_q;

  always_comb begin
    qd_prod  = {9'b0, q4_q} * {30'b0, row.den};
    rem_full = p4_q - qd_prod[29:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      r_q     <= rem_full[8:0];
      q5_q    <= q4_q;
      psym5_q <= psym4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: fractional part, floor(r * 2^s / den)
  // ---------------------------------------------------------------------------
  logic [20:0] r_sh;
  logic [51:0] low_prod;
  logic [12:0] low_q;
  logic [29:0] q6_q;
  logic [PsymW-1:0] psym6_q;

  always_comb begin
    r_sh     = {12'b0, r_q} << s_amt;
    low_prod = {31'b0, r_sh} * {21'b0, row.recip};
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      low_q   <= 13'(low_prod >> row.shr);
      q6_q    <= q5_q;
      psym6_q <= psym5_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: output register, airtime = q * 2^s + fraction
  // ---------------------------------------------------------------------------
  logic [41:0] t_full;
  logic [AirW-1:0]  air_q;
  logic [PsymW-1:0] psym7_q;
  logic             de_q;

  assign t_full = ({12'b0, q6_q} << s_amt) + {29'b0, low_q};

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      air_q   <= t_full[AirW-1:0];
      psym7_q <= psym6_q;
      de_q    <= de_c;
    end
  end

  assign m_axis_tvalid_o = v_q[NumStg-1];
  assign m_axis_tdata_o  = {1'b0, air_q, psym7_q, de_q};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // an empty output stage frees the whole chain
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with output stage empty");

  // reciprocal quotient must leave a proper remainder
  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> (rem_full < {21'b0, row.den}))
    else $error("airtime remainder out of range");

  // fractional term stays below one unit of the shifted quotient
  a_frac_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[6] |-> (({8'b0, low_q} >> s_amt) == 21'd0))
    else $error("airtime fraction overflow");

  // every result carries at least the eight base symbols
  a_psym_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (psym7_q >= 10'd8))
    else $error("payload symbol count below base");

endmodule

`default_nettype wire
